FILE: design/cbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the chunked body decoder
// Byte classification record, parser phase codes, status codes and sizes.
// ----------------------------------------------------------------------------
package cbd_pkg;

	// size line limits
	localparam int unsigned MAX_SIZE_DIGITS = 8;
	localparam int unsigned DIG_W           = 4;
	localparam int unsigned SIZE_W          = 32;
	localparam int unsigned LEN_W           = 16;

	// queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// parser phases
	localparam logic [2:0] PH_SIZE_START  = 3'd0;
	localparam logic [2:0] PH_SIZE_DIGITS = 3'd1;
	localparam logic [2:0] PH_EXPECT_LF   = 3'd2;
	localparam logic [2:0] PH_DATA        = 3'd3;
	localparam logic [2:0] PH_SKIP        = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_FIRST = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
	localparam logic [2:0] ST_NO_LF     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// one classified body word
	typedef struct packed {
		logic [7:0] body_byte;
		logic       hex_ok;
		logic [3:0] nibble;
		logic       is_cr;
		logic       is_lf;
		logic       first;
		logic       last;
	} cbd_item_t;

endpackage
`default_nettype wire

FILE: design/cbd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_front: input stage
// Takes body words, decodes hex digits and CR/LF, and hands them to the queue.
// ----------------------------------------------------------------------------
module cbd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       body_byte,
	input  wire logic             first_of_body,
	input  wire logic             last_of_body,
	output logic                  item_valid,
	input  wire logic             item_ready,
	output cbd_pkg::cbd_item_t    item
);
	import cbd_pkg::*;

	logic      valid_s1;
	cbd_item_t item_s1;
	cbd_item_t item_c;

	// classify the incoming byte
	always_comb begin
		item_c           = '0;
		item_c.body_byte = body_byte;
		item_c.first     = first_of_body;
		item_c.last      = last_of_body;
		item_c.is_cr     = (body_byte == CHAR_CR);
		item_c.is_lf     = (body_byte == CHAR_LF);
		if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
			item_c.hex_ok = 1'b1;
			item_c.nibble = body_byte[3:0];
		end else if ((body_byte >= 8'h41 && body_byte <= 8'h46) ||
		             (body_byte >= 8'h61 && body_byte <= 8'h66)) begin
			item_c.hex_ok = 1'b1;
			item_c.nibble = 4'(body_byte[2:0] + 3'd0) + 4'd9;
		end
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

FILE: design/cbd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_queue: short word queue
// Small register FIFO that decouples the input stage from the parser.
// ----------------------------------------------------------------------------
module cbd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire cbd_pkg::cbd_item_t push_item,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output cbd_pkg::cbd_item_t    pop_item
);
	import cbd_pkg::*;

	cbd_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

FILE: design/cbd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_back: chunk parser
// Walks size lines, passes chunk data, latches errors, and holds the result.
// ----------------------------------------------------------------------------
module cbd_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [cbd_pkg::LEN_W-1:0] capacity,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire cbd_pkg::cbd_item_t        item,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           data_valid,
	output logic [7:0]                     decoded_byte,
	output logic [2:0]                     status,
	output logic                           body_done,
	output logic [cbd_pkg::LEN_W-1:0]      decoded_length
);
	import cbd_pkg::*;

	// parser state
	logic [2:0]        phase_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] acc_q;
	logic [DIG_W-1:0]  dig_q;
	logic              tp_q;
	logic [LEN_W-1:0]  emit_q;
	logic [2:0]        err_q;

	// next values
	logic [2:0]        ph_n;
	logic [SIZE_W-1:0] rem_n;
	logic [SIZE_W-1:0] acc_n;
	logic [DIG_W-1:0]  dig_n;
	logic              tp_n;
	logic [LEN_W-1:0]  emit_n;
	logic [2:0]        err_n;
	logic              new_err;
	logic              dv_n;
	logic              take;
	logic              pop;

	// output register
	logic              out_valid_q;
	logic              dv_q;
	logic [7:0]        byte_q;
	logic [2:0]        status_q;
	logic              done_q;
	logic [LEN_W-1:0]  len_q;

	assign item_ready = !out_valid_q || out_ready;
	assign pop        = item_valid && item_ready;

	// one parser step
	always_comb begin
		ph_n    = item.first ? PH_SIZE_START : phase_q;
		rem_n   = item.first ? '0 : rem_q;
		acc_n   = item.first ? '0 : acc_q;
		dig_n   = item.first ? '0 : dig_q;
		tp_n    = item.first ? 1'b0 : tp_q;
		emit_n  = item.first ? '0 : emit_q;
		err_n   = item.first ? ST_OK : err_q;
		new_err = 1'b0;
		dv_n    = 1'b0;
		take    = 1'b0;
		if (err_n == ST_OK) begin
			case (ph_n)
				PH_SIZE_START: begin
					if (item.hex_ok) begin
						acc_n = '0;
						dig_n = '0;
						take  = 1'b1;
						ph_n  = PH_SIZE_DIGITS;
					end else begin
						err_n   = ST_BAD_FIRST;
						new_err = 1'b1;
					end
				end
				PH_SIZE_DIGITS: begin
					if (item.hex_ok) begin
						take = 1'b1;
					end else if (item.is_cr) begin
						ph_n = PH_EXPECT_LF;
					end else begin
						err_n   = ST_BAD_CHAR;
						new_err = 1'b1;
					end
				end
				PH_EXPECT_LF: begin
					if (item.is_lf) begin
						rem_n = (dig_n > DIG_W'(MAX_SIZE_DIGITS)) ? '0 : acc_n;
						acc_n = '0;
						dig_n = '0;
						if (rem_n != '0) begin
							ph_n = PH_DATA;
						end else begin
							ph_n = PH_SKIP;
							tp_n = 1'b1;
						end
					end else begin
						err_n   = ST_NO_LF;
						new_err = 1'b1;
					end
				end
				PH_DATA: begin
					if (emit_n >= capacity) begin
						err_n   = ST_OVERFLOW;
						new_err = 1'b1;
					end else begin
						dv_n   = 1'b1;
						emit_n = emit_n + 1'b1;
						rem_n  = rem_n - 1'b1;
						if (rem_n == '0) begin
							ph_n = PH_SKIP;
							tp_n = 1'b1;
						end
					end
				end
				default: begin
					// chunk trailer: two bytes dropped unchecked
					if (tp_n) begin
						tp_n = 1'b0;
					end else begin
						ph_n = PH_SIZE_START;
					end
				end
			endcase
			// shift in a size digit, saturate the count past the limit
			if (take) begin
				if (dig_n < DIG_W'(MAX_SIZE_DIGITS)) begin
					acc_n = {acc_n[SIZE_W-5:0], item.nibble};
					dig_n = dig_n + 1'b1;
				end else begin
					dig_n = DIG_W'(MAX_SIZE_DIGITS + 1);
				end
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE_START;
			rem_q   <= '0;
			acc_q   <= '0;
			dig_q   <= '0;
			tp_q    <= 1'b0;
			emit_q  <= '0;
			err_q   <= ST_OK;
		end else if (pop) begin
			phase_q <= ph_n;
			rem_q   <= rem_n;
			acc_q   <= acc_n;
			dig_q   <= dig_n;
			tp_q    <= tp_n;
			emit_q  <= emit_n;
			err_q   <= err_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dv_q     <= dv_n;
			byte_q   <= dv_n ? item.body_byte : 8'h00;
			status_q <= err_n;
			done_q   <= item.last || new_err;
			len_q    <= emit_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_valid     = dv_q;
	assign decoded_byte   = byte_q;
	assign status         = status_q;
	assign body_done      = done_q;
	assign decoded_length = len_q;

`ifndef SYNTHESIS
	// trailer flag only lives in the skip phase
	a_tp_in_skip: assert property (@(posedge clk) disable iff (!arst_n)
		tp_q |-> (phase_q == PH_SKIP))
		else $error("trailer flag outside skip phase");

	// data phase always has bytes left
	a_data_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_q != '0))
		else $error("data phase with zero bytes remaining");

	// a payload word is never shown with an error status
	a_dv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dv_q) |-> (status_q == ST_OK))
		else $error("payload word with error status");

	// every word taken from the queue yields a result next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("accepted word produced no result");

	// an emitted payload advances the length by one
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && dv_n && !item.first) |=> (emit_q == $past(emit_q) + 1'b1))
		else $error("length did not advance on payload");
`endif

endmodule
`default_nettype wire

FILE: design/chunked_body_decoder.sv
`default_nettype none
// Path: an accepted word passes the input stage register, a queue slot, then the parser result
//   register, and waits behind any words the queue already holds. Throughput: one word per cycle
//   while out_ready is high; the parser retires one word per cycle from a 4-entry queue.
// Reset: arst_n clears parser state, queue and valid flags at once; capacity returns to 65535.
// ----------------------------------------------------------------------------
// chunked_body_decoder: HTTP chunked transfer body decoder
// Front stage classifies bytes, a short queue feeds the chunk parser back end.
// ----------------------------------------------------------------------------
module chunked_body_decoder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [cbd_pkg::LEN_W-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                body_byte,
	input  wire logic                      first_of_body,
	input  wire logic                      last_of_body,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           data_valid,
	output logic [7:0]                     decoded_byte,
	output logic [2:0]                     status,
	output logic                           body_done,
	output logic [cbd_pkg::LEN_W-1:0]      decoded_length
);
	import cbd_pkg::*;

	logic [LEN_W-1:0] output_capacity_q;
	logic             f_valid;
	logic             f_ready;
	cbd_item_t        f_item;
	logic             q_valid;
	logic             q_ready;
	cbd_item_t        q_item;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_capacity_q <= '1;
		end else if (cfg_wr_en) begin
			output_capacity_q <= cfg_wr_data;
		end
	end

	cbd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.body_byte     (body_byte),
		.first_of_body (first_of_body),
		.last_of_body  (last_of_body),
		.item_valid    (f_valid),
		.item_ready    (f_ready),
		.item          (f_item)
	);

	cbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	cbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity       (output_capacity_q),
		.item_valid     (q_valid),
		.item_ready     (q_ready),
		.item           (q_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_valid     (data_valid),
		.decoded_byte   (decoded_byte),
		.status         (status),
		.body_done      (body_done),
		.decoded_length (decoded_length)
	);

endmodule
`default_nettype wire

FILE: tb/sv/cbd_checker.sv
// ----------------------------------------------------------------------------
// cbd_checker: result predictor and scoreboard for the chunked body decoder
// Runs every accepted body word through a private model of the chunk parser,
// queues the predicted result and compares it with each delivered result.
// ----------------------------------------------------------------------------
module cbd_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [cbd_pkg::LEN_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                body_byte,
	input  logic                      first_of_body,
	input  logic                      last_of_body,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      data_valid,
	input  logic [7:0]                decoded_byte,
	input  logic [2:0]                status,
	input  logic                      body_done,
	input  logic [cbd_pkg::LEN_W-1:0] decoded_length,
	output int                        mismatches,
	output int                        pending,
	output int                        payload_bytes,
	output int                        error_events
);
	import cbd_pkg::*;

	typedef struct packed {
		logic             data_valid;
		logic [7:0]       data;
		logic [2:0]       status;
		logic             done;
		logic [LEN_W-1:0] length;
	} decode_result_t;

	// parser model state
	logic [2:0]        ph;
	logic [SIZE_W-1:0] chunk_left;
	logic [SIZE_W-1:0] size_acc;
	logic [DIG_W-1:0]  digit_cnt;
	logic              trailer_due;
	logic [LEN_W-1:0]  emitted;
	logic [2:0]        latched_err;
	logic [LEN_W-1:0]  capacity;

	decode_result_t pending_results[$];
	int results_seen;

	// state cleared by reset and by the first word of a body
	function automatic void restart_parse();
		ph          = PH_SIZE_START;
		chunk_left  = '0;
		size_acc    = '0;
		digit_cnt   = '0;
		trailer_due = 1'b0;
		emitted     = '0;
		latched_err = ST_OK;
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
			return {1'b0, d[3:0]};
		end
		if (c >= "A" && c <= "F") begin
			d = c - "A" + 8'd10;
			return {1'b0, d[3:0]};
		end
		if (c >= "a" && c <= "f") begin
			d = c - "a" + 8'd10;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

	// digits past the limit only saturate the count
	function automatic void add_size_digit(input logic [3:0] nib);
		if (digit_cnt < MAX_SIZE_DIGITS) begin
			size_acc  = {size_acc[SIZE_W-5:0], nib};
			digit_cnt = digit_cnt + 1'b1;
		end else begin
			digit_cnt = DIG_W'(MAX_SIZE_DIGITS + 1);
		end
	endfunction

	// one body word in, one predicted result out
	task automatic parse_body_word(input logic [7:0] b, input logic first, input logic last,
			output decode_result_t r);
		logic [4:0] nib;
		logic       raised;
		r      = '0;
		raised = 1'b0;
		if (first)
			restart_parse();
		if (latched_err == ST_OK) begin
			nib = hex_nibble(b);
			case (ph)
			PH_SIZE_START: begin
				if (!nib[4]) begin
					size_acc  = '0;
					digit_cnt = '0;
					add_size_digit(nib[3:0]);
					ph = PH_SIZE_DIGITS;
				end else begin
					latched_err = ST_BAD_FIRST;
					raised      = 1'b1;
				end
			end
			PH_SIZE_DIGITS: begin
				if (!nib[4]) begin
					add_size_digit(nib[3:0]);
				end else if (b == CHAR_CR) begin
					ph = PH_EXPECT_LF;
				end else begin
					latched_err = ST_BAD_CHAR;
					raised      = 1'b1;
				end
			end
			PH_EXPECT_LF: begin
				if (b == CHAR_LF) begin
					chunk_left = (digit_cnt > MAX_SIZE_DIGITS) ? '0 : size_acc;
					size_acc   = '0;
					digit_cnt  = '0;
					if (chunk_left != 0) begin
						ph = PH_DATA;
					end else begin
						ph          = PH_SKIP;
						trailer_due = 1'b1;
					end
				end else begin
					latched_err = ST_NO_LF;
					raised      = 1'b1;
				end
			end
			PH_DATA: begin
				if (emitted >= capacity) begin
					latched_err = ST_OVERFLOW;
					raised      = 1'b1;
				end else begin
					r.data_valid = 1'b1;
					r.data       = b;
					emitted      = emitted + 1'b1;
					chunk_left   = chunk_left - 1'b1;
					if (chunk_left == 0) begin
						ph          = PH_SKIP;
						trailer_due = 1'b1;
					end
				end
			end
			default: begin
				// two bytes after a chunk pass unchecked
				if (trailer_due)
					trailer_due = 1'b0;
				else
					ph = PH_SIZE_START;
			end
			endcase
		end
		r.status = latched_err;
		r.done   = last || raised;
		r.length = emitted;
		if (r.data_valid)
			payload_bytes++;
		if (raised)
			error_events++;
	endtask

	// watch both channels and the register port at every rising edge
	always @(posedge clk or negedge arst_n) begin
		decode_result_t want;
		decode_result_t got;
		if (!arst_n) begin
			restart_parse();
			capacity = '1;
			pending_results.delete();
			pending       = 0;
			mismatches    = 0;
			payload_bytes = 0;
			error_events  = 0;
			results_seen  = 0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;

			// results leave before the word of this edge can produce one
			if (out_valid && out_ready) begin
				got.data_valid = data_valid;
				got.data       = decoded_byte;
				got.status     = status;
				got.done       = body_done;
				got.length     = decoded_length;
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d arrived with nothing pending: dv=%0b byte=%02h st=%0d done=%0b len=%0d",
							results_seen, got.data_valid, got.data, got.status, got.done,
							got.length);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got.data_valid !== want.data_valid || got.data !== want.data ||
							got.status !== want.status || got.done !== want.done ||
							got.length !== want.length) begin
						if (mismatches < 10) begin
							$display("result %0d mismatch", results_seen);
							$display("  want dv=%0b byte=%02h st=%0d done=%0b len=%0d",
								want.data_valid, want.data, want.status, want.done,
								want.length);
							$display("  got  dv=%0b byte=%02h st=%0d done=%0b len=%0d",
								got.data_valid, got.data, got.status, got.done,
								got.length);
						end
						mismatches++;
					end
				end
				results_seen++;
			end

			if (in_valid && in_ready) begin
				parse_body_word(body_byte, first_of_body, last_of_body, want);
				pending_results.push_back(want);
			end
			pending = pending_results.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the chunked body decoder
// Sends directed and random chunked bodies under several output capacities
// with random gaps and stalls; cbd_checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;
	import cbd_pkg::*;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic [7:0]       body_byte     = '0;
	logic             first_of_body = 1'b0;
	logic             last_of_body  = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             data_valid;
	logic [7:0]       decoded_byte;
	logic [2:0]       status;
	logic             body_done;
	logic [LEN_W-1:0] decoded_length;

	int mismatches;
	int pending;
	int payload_bytes;
	int error_events;

	int   words_sent    = 0;
	int   bodies_sent   = 0;
	int   settings_used = 1;
	int   ready_hold    = 0;
	bit   steady        = 1'b0;   // no gaps or stalls while set
	logic [7:0] body_q[$];

	chunked_body_decoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.body_byte      (body_byte),
		.first_of_body  (first_of_body),
		.last_of_body   (last_of_body),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_valid     (data_valid),
		.decoded_byte   (decoded_byte),
		.status         (status),
		.body_done      (body_done),
		.decoded_length (decoded_length)
	);

	cbd_checker u_checker (.*);

	always #4 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: after each result, hold ready low for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ready_hold = steady ? 0 : $urandom_range(0, 3);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (ready_hold != 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one word: random gap, then hold valid until accepted
	task automatic push_word(input logic [7:0] b, input logic first, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		body_byte     <= b;
		first_of_body <= first;
		last_of_body  <= last;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_text(input string s, input logic first, input logic last);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], first && i == 0, last && i == s.len() - 1);
	endtask

	// stop sending until every pending result is back, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [LEN_W-1:0] cap);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// hex digit in random letter case
	function automatic void add_hex(input logic [3:0] nib);
		if (nib < 10)
			body_q.push_back("0" + nib);
		else if ($urandom_range(0, 1))
			body_q.push_back("A" + nib - 4'd10);
		else
			body_q.push_back("a" + nib - 4'd10);
	endfunction

	// a chunked body with random content, now and then damaged
	task automatic build_body();
		int chunks, pick, sz, nd, spot;
		logic [31:0] val;
		body_q.delete();
		chunks = $urandom_range(0, 3);
		repeat (chunks) begin
			pick = $urandom_range(0, 15);
			nd   = 0;
			val  = '0;
			if (pick == 0) begin
				// more than eight digits: size reads as zero
				repeat ($urandom_range(9, 11)) add_hex(4'($urandom_range(0, 15)));
				sz = 0;
			end else if (pick == 1) begin
				// top bit set: unsigned count, chunk outlives the body
				val = $urandom | 32'h8000_0000;
				nd  = 8;
				sz  = $urandom_range(0, 6);
			end else begin
				sz  = $urandom_range(1, 40);
				val = sz;
				nd  = (sz > 15 ? 2 : 1) + $urandom_range(0, 2);
			end
			for (int i = nd - 1; i >= 0; i--)
				add_hex(val[4*i +: 4]);
			body_q.push_back(CHAR_CR);
			body_q.push_back(CHAR_LF);
			repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) != 0) begin
				body_q.push_back(CHAR_CR);
				body_q.push_back(CHAR_LF);
			end else begin
				body_q.push_back(8'($urandom_range(0, 255)));
				body_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		// closing zero chunk and empty line
		repeat ($urandom_range(1, 3)) add_hex(4'h0);
		body_q.push_back(CHAR_CR);
		body_q.push_back(CHAR_LF);
		body_q.push_back(CHAR_CR);
		body_q.push_back(CHAR_LF);
		if ($urandom_range(0, 7) == 0)
			body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			spot = $urandom_range(1, body_q.size() - 1);
			while (body_q.size() > spot) void'(body_q.pop_back());
		end
	endtask

	task automatic send_body();
		for (int i = 0; i < body_q.size(); i++)
			push_word(body_q[i], i == 0, i == body_q.size() - 1);
		bodies_sent++;
	endtask

	// mostly well-formed bodies, some loose words with random flags
	task automatic random_phase(input int words);
		int stop_at, len;
		stop_at = words_sent + words;
		while (words_sent < stop_at) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 6);
				repeat (len)
					push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0);
			end else begin
				build_body();
				send_body();
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: bad first char, then a word ignored under the latched error
		send_text("/", 1'b1, 1'b0);
		send_text("F", 1'b0, 1'b1);
		// bad char inside the size line
		send_text("fg", 1'b1, 1'b0);
		// CR not followed by LF
		send_text("A\015\013", 1'b1, 1'b0);
		// huge size, data extremes, last word mid-chunk, then the chunk goes on
		send_text("80000000\015\012", 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b1);
		push_word(8'hFF, 1'b0, 1'b0);
		// nine digits: size taken as zero
		send_text("000000009\015\012", 1'b1, 1'b1);

		// random bodies under several capacities, extremes included
		set_capacity(16'h0000);
		random_phase(70);
		set_capacity(16'd1);
		random_phase(70);
		set_capacity(16'd7);
		random_phase(70);
		set_capacity(LEN_W'($urandom_range(8, 60)));
		random_phase(70);
		set_capacity(16'd30);
		random_phase(70);
		set_capacity(16'hFFFF);
		random_phase(70);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Run: %0d body words in %0d random bodies under %0d capacity settings",
			words_sent, bodies_sent, settings_used);
		$display("Run: %0d payload bytes and %0d parse errors predicted, %0d mismatches",
			payload_bytes, error_events, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: chunked_body_decoder.f
design/cbd_pkg.sv
design/cbd_front.sv
design/cbd_queue.sv
design/cbd_back.sv
design/chunked_body_decoder.sv
tb/sv/cbd_checker.sv
tb/sv/tb.sv
